>>> sv/fclcm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and arithmetic helpers of the five-channel light color mapper.
// No dependencies; imported by the controller, the datapath and the top level.
package fclcm_pkg;

	localparam int HUE_W  = 9;
	localparam int PCT_W  = 7;
	localparam int DUTY_W = 8;
	localparam int FADE_W = 16;
	localparam int NCH    = 5;
	localparam int PROD_W = 20;
	localparam int MULB_W = 14;
	localparam int QUOT_W = 14;
	localparam int STEP_W = 5;
	localparam int OP_W   = 5;
	localparam int IDX_W  = 3;

	localparam logic [HUE_W-1:0]  HUE_FULL  = 9'd360;
	localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;
	localparam logic [PCT_W-1:0]  KNEE_AT   = 7'd15;
	localparam logic [PCT_W-1:0]  KNEE_BASE = 7'd14;
	localparam logic [MULB_W-1:0] KNEE_GAIN = 14'd86;
	localparam logic [MULB_W-1:0] FULL_DUTY = 14'd255;
	localparam logic [MULB_W-1:0] TEN_K     = 14'd10000;
	localparam logic [MULB_W-1:0] HUNDRED_B = 14'd100;

	// x / 100 as (x * 671089) >> 26, exact for x < 2**20
	localparam logic [PROD_W-1:0] DIV100_MUL   = 20'd671089;
	localparam int                DIV100_SHIFT = 26;
	// floor(5 * rem / 3) as (rem * 855) >> 9, exact for rem < 60
	localparam logic [15:0]       FRAC_MUL     = 16'd855;

	localparam logic [1:0] OPC_COLOUR = 2'd0;
	localparam logic [1:0] OPC_WHITE  = 2'd1;
	localparam logic [1:0] OPC_SWITCH = 2'd2;

	localparam logic MODE_COLOUR = 1'b0;
	localparam logic MODE_WHITE  = 1'b1;

	localparam logic [1:0] KIND_REJECT = 2'd0;
	localparam logic [1:0] KIND_OFF    = 2'd1;
	localparam logic [1:0] KIND_COLOUR = 2'd2;
	localparam logic [1:0] KIND_WHITE  = 2'd3;

	localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
	localparam logic [OP_W-1:0] OP_PREP      = 5'd1;
	localparam logic [OP_W-1:0] OP_MUL_FS    = 5'd2;
	localparam logic [OP_W-1:0] OP_MUL_SF    = 5'd3;
	localparam logic [OP_W-1:0] OP_MUL_VC    = 5'd4;
	localparam logic [OP_W-1:0] OP_MUL_VS    = 5'd5;
	localparam logic [OP_W-1:0] OP_DIV_TMP   = 5'd6;
	localparam logic [OP_W-1:0] OP_DIV_PQT   = 5'd7;
	localparam logic [OP_W-1:0] OP_DIVP_PQT  = 5'd8;
	localparam logic [OP_W-1:0] OP_SEL_RGB   = 5'd9;
	localparam logic [OP_W-1:0] OP_MUL_CTBR  = 5'd10;
	localparam logic [OP_W-1:0] OP_MUL_ICTBR = 5'd11;
	localparam logic [OP_W-1:0] OP_DIV_CH    = 5'd12;
	localparam logic [OP_W-1:0] OP_MUL_KNEE  = 5'd13;
	localparam logic [OP_W-1:0] OP_KNEE      = 5'd14;
	localparam logic [OP_W-1:0] OP_MUL_SCALE = 5'd15;
	localparam logic [OP_W-1:0] OP_DIV_DUTY  = 5'd16;

	localparam logic [IDX_W-1:0] CH_RED  = 3'd0;
	localparam logic [IDX_W-1:0] CH_GRN  = 3'd1;
	localparam logic [IDX_W-1:0] CH_BLU  = 3'd2;
	localparam logic [IDX_W-1:0] CH_WARM = 3'd3;
	localparam logic [IDX_W-1:0] CH_COLD = 3'd4;
	localparam logic [IDX_W-1:0] SLOT_P  = 3'd0;
	localparam logic [IDX_W-1:0] SLOT_Q  = 3'd1;
	localparam logic [IDX_W-1:0] SLOT_T  = 3'd2;

	localparam logic [STEP_W-1:0] COLOUR_LAST = 5'd17;
	localparam logic [STEP_W-1:0] WHITE_LAST  = 5'd11;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
	} uop_t;

	typedef struct packed {
		logic load;
		logic push;
		uop_t uop;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
	} dp_status_t;

	function automatic uop_t mk_uop(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
		uop_t u;
		u.op  = op;
		u.idx = idx;
		return u;
	endfunction

	function automatic logic [QUOT_W-1:0] div100(input logic [PROD_W-1:0] x);
		logic [2*PROD_W-1:0] pr;
		pr = (2*PROD_W)'(x) * (2*PROD_W)'(DIV100_MUL);
		return pr[DIV100_SHIFT +: QUOT_W];
	endfunction

	function automatic uop_t colour_uop(input logic [STEP_W-1:0] step);
		uop_t u;
		case (step)
			5'd0:  u = mk_uop(OP_PREP, SLOT_P);
			5'd1:  u = mk_uop(OP_MUL_FS, SLOT_P);
			5'd2:  u = mk_uop(OP_MUL_VC, SLOT_P);
			5'd3:  u = mk_uop(OP_DIV_TMP, SLOT_P);
			5'd4:  u = mk_uop(OP_DIV_PQT, SLOT_Q);
			5'd5:  u = mk_uop(OP_MUL_SF, SLOT_P);
			5'd6:  u = mk_uop(OP_MUL_VC, SLOT_P);
			5'd7:  u = mk_uop(OP_DIV_TMP, SLOT_P);
			5'd8:  u = mk_uop(OP_DIV_PQT, SLOT_T);
			5'd9:  u = mk_uop(OP_MUL_VS, SLOT_P);
			5'd10: u = mk_uop(OP_DIVP_PQT, SLOT_P);
			5'd11: u = mk_uop(OP_SEL_RGB, CH_RED);
			5'd12: u = mk_uop(OP_MUL_SCALE, CH_RED);
			5'd13: u = mk_uop(OP_DIV_DUTY, CH_RED);
			5'd14: u = mk_uop(OP_MUL_SCALE, CH_GRN);
			5'd15: u = mk_uop(OP_DIV_DUTY, CH_GRN);
			5'd16: u = mk_uop(OP_MUL_SCALE, CH_BLU);
			5'd17: u = mk_uop(OP_DIV_DUTY, CH_BLU);
			default: u = mk_uop(OP_NOP, CH_RED);
		endcase
		return u;
	endfunction

	function automatic uop_t white_uop(input logic [STEP_W-1:0] step);
		uop_t u;
		case (step)
			5'd0:  u = mk_uop(OP_MUL_CTBR, CH_WARM);
			5'd1:  u = mk_uop(OP_DIV_CH, CH_WARM);
			5'd2:  u = mk_uop(OP_MUL_ICTBR, CH_COLD);
			5'd3:  u = mk_uop(OP_DIV_CH, CH_COLD);
			5'd4:  u = mk_uop(OP_MUL_KNEE, CH_WARM);
			5'd5:  u = mk_uop(OP_KNEE, CH_WARM);
			5'd6:  u = mk_uop(OP_MUL_KNEE, CH_COLD);
			5'd7:  u = mk_uop(OP_KNEE, CH_COLD);
			5'd8:  u = mk_uop(OP_MUL_SCALE, CH_WARM);
			5'd9:  u = mk_uop(OP_DIV_DUTY, CH_WARM);
			5'd10: u = mk_uop(OP_MUL_SCALE, CH_COLD);
			5'd11: u = mk_uop(OP_DIV_DUTY, CH_COLD);
			default: u = mk_uop(OP_NOP, CH_RED);
		endcase
		return u;
	endfunction

endpackage

>>> sv/five_channel_light_color_mapper.sv
`timescale 1ns / 1ps
// Five-channel light color mapper: lamp commands in, five channel duties out.
// Depends on fclcm_pkg, fclcm_ctrl and fclcm_datapath.
//
// Channels: s_* carries one lamp command per transfer (opcode in s_tuser), m_* one
// result per command (five duties and fade time in m_tdata, reject flag in m_tuser),
// cfg_* writes the fade time register; the user writes it only while the block is
// idle, a rule that the block itself leaves unenforced. One command is in work
// at a time; s_tready is high only while the block is idle. A color command runs
// the color micro-op sequence and a white command the shorter white one; switch-on
// runs the sequence of the current mode, and switch-off or a rejected command none.
// The micro-op sequence uses one shared multiplier and one divide-by-100 unit,
// each used once per cycle on one operation.
// The next command is taken in the cycle after a result is loaded into the output
// register, so a result may wait for m_tready while the next command is worked on.
// When the receiver stalls a finished result stays in the output register and the
// controller holds its next result until the register is free.
// Reset: color mode, lamp on, hue 360, saturation 0, level 100, white share 0,
// brightness 30, fade time 0, no result pending.
module five_channel_light_color_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // hue[8:0], saturation[15:9], level[22:16],
	                               // warm_share[29:23], brightness[36:30],
	                               // switch_on[37], zero[39:38]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // red_duty[7:0], green_duty[15:8], blue_duty[23:16],
	                               // warm_duty[31:24], cold_duty[39:32], fade_ms[55:40]
	output logic        m_tuser,   // status[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // fade_time[15:0]
);
	import fclcm_pkg::*;

	logic [FADE_W-1:0]          fade_q;
	dp_cmd_t                    cmd;
	dp_status_t                 status;
	logic [NCH-1:0][DUTY_W-1:0] out_duty;
	logic [FADE_W-1:0]          out_fade;
	logic                       out_reject;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			fade_q <= cfg_data;
		end
	end

	fclcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	fclcm_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.opcode            (s_tuser),
		.hue               (s_tdata[8:0]),
		.saturation        (s_tdata[15:9]),
		.level             (s_tdata[22:16]),
		.warm_share        (s_tdata[29:23]),
		.brightness        (s_tdata[36:30]),
		.switch_on         (s_tdata[37]),
		.fade_time         (fade_q),
		.out_duty          (out_duty),
		.out_fade          (out_fade),
		.out_reject        (out_reject)
	);

	assign m_tdata = {out_fade, out_duty};
	assign m_tuser = out_reject;

endmodule

>>> sv/fclcm_ctrl.sv
`timescale 1ns / 1ps
// Controller of the light color mapper: input/output handshake and micro-op sequencer.
// Depends on fclcm_pkg; drives fclcm_datapath through dp_cmd_t.
module fclcm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  fclcm_pkg::dp_status_t  status,
	output fclcm_pkg::dp_cmd_t     cmd
);
	import fclcm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]        state_q;
	logic              white_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              accept;
	logic              last;
	logic              slot_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign slot_free = !out_valid_q || m_tready;
	assign last      = (step_q == (white_q ? WHITE_LAST : COLOUR_LAST));

	always_comb begin
		cmd.load = accept;
		cmd.push = (state_q == ST_PUSH) && slot_free;
		if (state_q == ST_RUN) begin
			cmd.uop = white_q ? white_uop(step_q) : colour_uop(step_q);
		end else begin
			cmd.uop = mk_uop(OP_NOP, CH_RED);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			white_q     <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q  <= '0;
						white_q <= (status.kind == KIND_WHITE);
						if (status.kind inside {KIND_COLOUR, KIND_WHITE}) begin
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_PUSH;
						end
					end
				end
				ST_RUN: begin
					if (last) begin
						state_q <= ST_PUSH;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_PUSH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/fclcm_datapath.sv
`timescale 1ns / 1ps
// Datapath of the light color mapper: lamp state, shared multiplier, divide-by-100 unit,
// work registers and output payload register. Depends on fclcm_pkg; commanded by fclcm_ctrl.
module fclcm_datapath (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  fclcm_pkg::dp_cmd_t                              cmd,
	output fclcm_pkg::dp_status_t                           status,
	input  logic [1:0]                                      opcode,
	input  logic [fclcm_pkg::HUE_W-1:0]                     hue,
	input  logic [fclcm_pkg::PCT_W-1:0]                     saturation,
	input  logic [fclcm_pkg::PCT_W-1:0]                     level,
	input  logic [fclcm_pkg::PCT_W-1:0]                     warm_share,
	input  logic [fclcm_pkg::PCT_W-1:0]                     brightness,
	input  logic                                            switch_on,
	input  logic [fclcm_pkg::FADE_W-1:0]                    fade_time,
	output logic [fclcm_pkg::NCH-1:0][fclcm_pkg::DUTY_W-1:0] out_duty,
	output logic [fclcm_pkg::FADE_W-1:0]                    out_fade,
	output logic                                            out_reject
);
	import fclcm_pkg::*;

	// lamp state
	logic             mode_q;
	logic             on_q;
	logic [HUE_W-1:0] hue_q;
	logic [PCT_W-1:0] sat_q;
	logic [PCT_W-1:0] lvl_q;
	logic [PCT_W-1:0] ct_q;
	logic [PCT_W-1:0] br_q;

	// work registers
	logic [HUE_W-1:0]  wa_q;
	logic [PCT_W-1:0]  wb_q;
	logic [PCT_W-1:0]  wv_q;
	logic [2:0]        sector_q;
	logic [PCT_W-1:0]  frac_q;
	logic [PROD_W-1:0] prod_q;
	logic [QUOT_W-1:0] div_q;
	logic [PCT_W-1:0]  pqt_q [3];
	logic [PCT_W-1:0]  ch_q [NCH];
	logic [DUTY_W-1:0] duty_q [NCH];
	logic              rej_q;

	logic [NCH-1:0][DUTY_W-1:0] out_duty_q;
	logic [FADE_W-1:0]          out_fade_q;
	logic                       out_rej_q;

	logic [1:0]        kind;
	logic [HUE_W-1:0]  hue_src;
	logic [HUE_W-1:0]  hue_eff;
	logic [PCT_W-1:0]  sat_src;
	logic [PCT_W-1:0]  lvl_eff;
	logic [PCT_W-1:0]  ct_src;
	logic [PCT_W-1:0]  br_eff;
	logic [2:0]        sector_d;
	logic [HUE_W-1:0]  sector_base;
	logic [5:0]        rem_d;
	logic [15:0]       frac_full;
	logic [PCT_W-1:0]  mul_a;
	logic [MULB_W-1:0] mul_b;
	logic [20:0]       mul_full;
	logic [PROD_W-1:0] div_in;
	logic [QUOT_W-1:0] div_out;
	logic [PCT_W-1:0]  ch_sel;
	logic [PCT_W-1:0]  v_r;
	logic [PCT_W-1:0]  v_g;
	logic [PCT_W-1:0]  v_b;

	// command decode and operand selection
	always_comb begin
		kind = KIND_REJECT;
		case (opcode)
			OPC_COLOUR: begin
				if (hue <= HUE_FULL && saturation <= PCT_MAX && level <= PCT_MAX) begin
					kind = KIND_COLOUR;
				end
			end
			OPC_WHITE: begin
				if (warm_share <= PCT_MAX && brightness <= PCT_MAX) begin
					kind = KIND_WHITE;
				end
			end
			OPC_SWITCH: begin
				if (!switch_on) begin
					kind = KIND_OFF;
				end else if (mode_q == MODE_WHITE) begin
					kind = KIND_WHITE;
				end else begin
					kind = KIND_COLOUR;
				end
			end
			default: begin
				kind = KIND_REJECT;
			end
		endcase
	end

	assign status.kind = kind;

	always_comb begin
		if (opcode == OPC_COLOUR) begin
			hue_src = hue;
			sat_src = saturation;
			lvl_eff = level;
		end else begin
			hue_src = hue_q;
			sat_src = sat_q;
			lvl_eff = (lvl_q == '0) ? PCT_MAX : lvl_q;
		end
		if (opcode == OPC_WHITE) begin
			ct_src = warm_share;
			br_eff = brightness;
		end else begin
			ct_src = ct_q;
			br_eff = (br_q == '0) ? PCT_MAX : br_q;
		end
		hue_eff = (hue_src >= HUE_FULL) ? '0 : hue_src;
	end

	// hue sector and fraction
	always_comb begin
		if (wa_q >= 9'd300) begin
			sector_d    = 3'd5;
			sector_base = 9'd300;
		end else if (wa_q >= 9'd240) begin
			sector_d    = 3'd4;
			sector_base = 9'd240;
		end else if (wa_q >= 9'd180) begin
			sector_d    = 3'd3;
			sector_base = 9'd180;
		end else if (wa_q >= 9'd120) begin
			sector_d    = 3'd2;
			sector_base = 9'd120;
		end else if (wa_q >= 9'd60) begin
			sector_d    = 3'd1;
			sector_base = 9'd60;
		end else begin
			sector_d    = 3'd0;
			sector_base = 9'd0;
		end
		rem_d     = 6'(wa_q - sector_base);
		frac_full = 16'(rem_d) * FRAC_MUL;
	end

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.uop.op)
			OP_MUL_FS: begin
				mul_a = frac_q;
				mul_b = MULB_W'(wb_q);
			end
			OP_MUL_SF: begin
				mul_a = wb_q;
				mul_b = MULB_W'(PCT_MAX - frac_q);
			end
			OP_MUL_VC: begin
				mul_a = wv_q;
				mul_b = TEN_K - prod_q[MULB_W-1:0];
			end
			OP_MUL_VS: begin
				mul_a = wv_q;
				mul_b = MULB_W'(PCT_MAX - wb_q);
			end
			OP_MUL_CTBR: begin
				mul_a = wa_q[PCT_W-1:0];
				mul_b = MULB_W'(wb_q);
			end
			OP_MUL_ICTBR: begin
				mul_a = PCT_MAX - wa_q[PCT_W-1:0];
				mul_b = MULB_W'(wb_q);
			end
			OP_MUL_KNEE: begin
				mul_a = ch_sel;
				mul_b = KNEE_GAIN;
			end
			OP_MUL_SCALE: begin
				mul_a = ch_sel;
				mul_b = FULL_DUTY;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_full = {14'b0, mul_a} * {7'b0, mul_b};
	end

	assign ch_sel  = ch_q[cmd.uop.idx];
	assign div_in  = (cmd.uop.op == OP_DIV_PQT) ? PROD_W'(div_q) : prod_q;
	assign div_out = div100(div_in);

	always_comb begin
		case (sector_q)
			3'd0: begin
				v_r = wv_q;      v_g = pqt_q[2]; v_b = pqt_q[0];
			end
			3'd1: begin
				v_r = pqt_q[1];  v_g = wv_q;     v_b = pqt_q[0];
			end
			3'd2: begin
				v_r = pqt_q[0];  v_g = wv_q;     v_b = pqt_q[2];
			end
			3'd3: begin
				v_r = pqt_q[0];  v_g = pqt_q[1]; v_b = wv_q;
			end
			3'd4: begin
				v_r = pqt_q[2];  v_g = pqt_q[0]; v_b = wv_q;
			end
			default: begin
				v_r = wv_q;      v_g = pqt_q[0]; v_b = pqt_q[1];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_COLOUR;
			on_q   <= 1'b1;
			hue_q  <= HUE_FULL;
			sat_q  <= '0;
			lvl_q  <= PCT_MAX;
			ct_q   <= '0;
			br_q   <= 7'd30;
		end else if (cmd.load) begin
			case (kind)
				KIND_COLOUR: begin
					mode_q <= MODE_COLOUR;
					on_q   <= 1'b1;
					hue_q  <= hue_src;
					sat_q  <= sat_src;
					lvl_q  <= lvl_eff;
				end
				KIND_WHITE: begin
					mode_q <= MODE_WHITE;
					on_q   <= 1'b1;
					ct_q   <= ct_src;
					br_q   <= br_eff;
				end
				KIND_OFF: begin
					on_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rej_q <= (kind == KIND_REJECT);
			for (int i = 0; i < NCH; i++) begin
				duty_q[i] <= '0;
			end
			if (kind == KIND_WHITE) begin
				wa_q <= HUE_W'(ct_src);
				wb_q <= br_eff;
			end else begin
				wa_q <= hue_eff;
				wb_q <= sat_src;
			end
			wv_q <= lvl_eff;
		end else begin
			case (cmd.uop.op)
				OP_PREP: begin
					sector_q <= sector_d;
					frac_q   <= frac_full[15:9];
				end
				OP_MUL_FS, OP_MUL_SF, OP_MUL_VC, OP_MUL_VS, OP_MUL_CTBR, OP_MUL_ICTBR,
				OP_MUL_KNEE, OP_MUL_SCALE: begin
					prod_q <= mul_full[PROD_W-1:0];
				end
				OP_DIV_TMP: begin
					div_q <= div_out;
				end
				OP_DIV_PQT, OP_DIVP_PQT: begin
					pqt_q[cmd.uop.idx[1:0]] <= div_out[PCT_W-1:0];
				end
				OP_SEL_RGB: begin
					ch_q[CH_RED] <= v_r;
					ch_q[CH_GRN] <= v_g;
					ch_q[CH_BLU] <= v_b;
				end
				OP_DIV_CH: begin
					ch_q[cmd.uop.idx] <= div_out[PCT_W-1:0];
				end
				OP_KNEE: begin
					if (ch_sel >= KNEE_AT) begin
						ch_q[cmd.uop.idx] <= KNEE_BASE + div_out[PCT_W-1:0];
					end
				end
				OP_DIV_DUTY: begin
					duty_q[cmd.uop.idx] <= div_out[DUTY_W-1:0];
				end
				default: begin
				end
			endcase
		end
		if (cmd.push) begin
			for (int i = 0; i < NCH; i++) begin
				out_duty_q[i] <= duty_q[i];
			end
			out_fade_q <= rej_q ? '0 : fade_time;
			out_rej_q  <= rej_q;
		end
	end

	assign out_duty   = out_duty_q;
	assign out_fade   = out_fade_q;
	assign out_reject = out_rej_q;

endmodule

>>> sv/fclcm_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the light color mapper and its bind to the top level.
// Depends only on the ports of five_channel_light_color_mapper.
module fclcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while one is in work");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 56'd0)
		else $error("rejected command carries nonzero payload");

	a_mode_split: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:0] == 24'd0 || m_tdata[39:24] == 16'd0)
		else $error("color and white channels both driven");

endmodule

bind five_channel_light_color_mapper fclcm_checker u_fclcm_checker (.*);

>>> test/tb_five_channel_light_color_mapper.sv
`timescale 1ns / 1ps
// Self-checking bench for five_channel_light_color_mapper: directed and random lamp
// commands, fade time rewrites between phases, result duties compared to a local model.
// Depends on fclcm_pkg and the five_channel_light_color_mapper RTL.
module tb_five_channel_light_color_mapper;
	import fclcm_pkg::*;

	localparam logic [1:0] OPC_UNUSED    = 2'd3;
	localparam logic       STATUS_OK     = 1'b0;
	localparam logic       STATUS_REJECT = 1'b1;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned QUIET_TAIL    = 150;
	localparam int unsigned LONG_HOLD_AT  = 300;
	localparam int unsigned LONG_HOLD_LEN = 300;
	localparam int unsigned DRAIN_CYCLES  = 25;

	typedef struct packed {
		logic [1:0] opcode;
		logic [8:0] hue;
		logic [6:0] sat;
		logic [6:0] lvl;
		logic [6:0] ct;
		logic [6:0] br;
		logic       on;
	} lamp_cmd_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  warm;
		logic [7:0]  cold;
		logic [15:0] fade;
		logic        status;
	} lamp_result_t;

	typedef struct packed {
		logic        is_fade;
		logic [15:0] fade_value;
		lamp_cmd_t   cmd;
	} pending_entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // hue[8:0], saturation[15:9], level[22:16],
	                             // warm_share[29:23], brightness[36:30],
	                             // switch_on[37], zero[39:38]
	logic [1:0]  s_tuser = '0;   // opcode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // red_duty[7:0], green_duty[15:8], blue_duty[23:16],
	                             // warm_duty[31:24], cold_duty[39:32], fade_ms[55:40]
	logic        m_tuser;        // status[0]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;  // fade_time[15:0]

	five_channel_light_color_mapper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	pending_entry_t pending[$];
	lamp_result_t   expected_results[$];
	int unsigned    n_issued = 0;
	int unsigned    n_recv = 0;
	int unsigned    n_total = 0;
	int unsigned    error_count = 0;
	int unsigned    cycle_count = 0;

	// model state
	logic        mode_now = MODE_COLOUR;
	logic        lamp_lit = 1'b1;
	logic [8:0]  keep_hue = HUE_FULL;
	logic [6:0]  keep_sat = '0;
	logic [6:0]  keep_level = PCT_MAX;
	logic [6:0]  keep_ct = '0;
	logic [6:0]  keep_bright = 7'd30;
	logic [15:0] fade_now = '0;

	function automatic lamp_result_t colour_mix(input int unsigned h, s, v);
		lamp_result_t r;
		int unsigned sector, frac, p, q, t, rr, gg, bb;
		r = '0;
		if (h >= 360)
			h = 0;
		sector = h / 60;
		frac = (100 * h) / 60 - 100 * sector;
		p = v * (100 - s) / 100;
		q = v * (10000 - frac * s) / 10000;
		t = v * (10000 - s * (100 - frac)) / 10000;
		case (sector)
			0: begin rr = v; gg = t; bb = p; end
			1: begin rr = q; gg = v; bb = p; end
			2: begin rr = p; gg = v; bb = t; end
			3: begin rr = p; gg = q; bb = v; end
			4: begin rr = t; gg = p; bb = v; end
			default: begin rr = v; gg = p; bb = q; end
		endcase
		r.red = 8'(rr * 255 / 100);
		r.green = 8'(gg * 255 / 100);
		r.blue = 8'(bb * 255 / 100);
		return r;
	endfunction

	function automatic int unsigned knee_bend(input int unsigned x);
		return (x < 15) ? x : 14 + x * 86 / 100;
	endfunction

	function automatic lamp_result_t white_mix(input int unsigned ct, br);
		lamp_result_t r;
		r = '0;
		r.warm = 8'(knee_bend(ct * br / 100) * 255 / 100);
		r.cold = 8'(knee_bend((100 - ct) * br / 100) * 255 / 100);
		return r;
	endfunction

	function automatic lamp_result_t apply_lamp_command(input lamp_cmd_t c);
		lamp_result_t r;
		logic ok;
		r = '0;
		ok = 1'b1;
		case (c.opcode)
			OPC_COLOUR: begin
				if (c.hue > HUE_FULL || c.sat > PCT_MAX || c.lvl > PCT_MAX) begin
					ok = 1'b0;
				end else begin
					r = colour_mix(c.hue, c.sat, c.lvl);
					mode_now = MODE_COLOUR;
					lamp_lit = 1'b1;
					keep_hue = c.hue;
					keep_sat = c.sat;
					keep_level = c.lvl;
				end
			end
			OPC_WHITE: begin
				if (c.ct > PCT_MAX || c.br > PCT_MAX) begin
					ok = 1'b0;
				end else begin
					r = white_mix(c.ct, c.br);
					mode_now = MODE_WHITE;
					lamp_lit = 1'b1;
					keep_ct = c.ct;
					keep_bright = c.br;
				end
			end
			OPC_SWITCH: begin
				if (!c.on) begin
					lamp_lit = 1'b0;
				end else begin
					lamp_lit = 1'b1;
					if (mode_now == MODE_COLOUR) begin
						if (keep_level == 0)
							keep_level = PCT_MAX;
						r = colour_mix(keep_hue, keep_sat, keep_level);
					end else begin
						if (keep_bright == 0)
							keep_bright = PCT_MAX;
						r = white_mix(keep_ct, keep_bright);
					end
				end
			end
			default: ok = 1'b0;
		endcase
		if (ok) begin
			r.fade = fade_now;
			r.status = STATUS_OK;
		end else begin
			r = '0;
			r.status = STATUS_REJECT;
		end
		return r;
	endfunction

	task automatic queue_cmd(input logic [1:0] op, input int unsigned hue, sat, lvl, ct, br,
			input bit on);
		pending_entry_t e;
		e = '0;
		e.cmd.opcode = op;
		e.cmd.hue = 9'(hue);
		e.cmd.sat = 7'(sat);
		e.cmd.lvl = 7'(lvl);
		e.cmd.ct = 7'(ct);
		e.cmd.br = 7'(br);
		e.cmd.on = on;
		pending.push_back(e);
		n_total++;
	endtask

	task automatic queue_fade(input logic [15:0] value);
		pending_entry_t e;
		e = '0;
		e.is_fade = 1'b1;
		e.fade_value = value;
		pending.push_back(e);
	endtask

	function automatic int unsigned pct_value();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 100;
			default: return $urandom_range(0, 100);
		endcase
	endfunction

	task automatic queue_random(input int unsigned count);
		int unsigned hue, pick;
		repeat (count) begin
			if ($urandom_range(0, 99) < 15) begin
				queue_cmd(2'($urandom), $urandom_range(0, 511), $urandom_range(0, 127),
					$urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
					1'($urandom));
			end else begin
				hue = ($urandom_range(0, 9) == 0) ? 360 : $urandom_range(0, 359);
				pick = $urandom_range(0, 99);
				if (pick < 40)
					queue_cmd(OPC_COLOUR, hue, pct_value(), pct_value(),
						$urandom_range(0, 127), $urandom_range(0, 127), 1'($urandom));
				else if (pick < 75)
					queue_cmd(OPC_WHITE, $urandom_range(0, 511), $urandom_range(0, 127),
						$urandom_range(0, 127), pct_value(), pct_value(), 1'($urandom));
				else
					queue_cmd(OPC_SWITCH, $urandom_range(0, 511), $urandom_range(0, 127),
						$urandom_range(0, 127), $urandom_range(0, 127),
						$urandom_range(0, 127), $urandom_range(0, 4) != 0);
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned idx, want, got);
		if (want != got) begin
			$display("%0t: result %0d %s mismatch: expected %0d, actual %0d",
				$time, idx, name, want, got);
			error_count++;
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// driver: commands and fade time writes from the pending queue
	int unsigned gap_left = 0;
	always @(posedge clk) begin : drive
		logic           nv_s, nv_c, sent;
		lamp_cmd_t      got;
		pending_entry_t head;
		if (arst_n) begin
			nv_s = s_tvalid;
			nv_c = cfg_valid;
			sent = 1'b0;
			if (s_tvalid && s_tready) begin
				got.opcode = s_tuser;
				got.hue = s_tdata[8:0];
				got.sat = s_tdata[15:9];
				got.lvl = s_tdata[22:16];
				got.ct = s_tdata[29:23];
				got.br = s_tdata[36:30];
				got.on = s_tdata[37];
				expected_results.push_back(apply_lamp_command(got));
				n_issued <= n_issued + 1;
				nv_s = 1'b0;
				sent = 1'b1;
				if (pending.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 11);
			end
			if (cfg_valid && cfg_ready) begin
				fade_now = cfg_data;
				nv_c = 1'b0;
			end
			if (!nv_s && !nv_c) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() > 0) begin
					head = pending[0];
					if (head.is_fade) begin
						// fade time only changes once every result is back
						if (!sent && n_recv == n_issued) begin
							void'(pending.pop_front());
							cfg_data <= head.fade_value;
							nv_c = 1'b1;
						end
					end else begin
						void'(pending.pop_front());
						s_tdata <= {2'b00, head.cmd.on, head.cmd.br, head.cmd.ct,
							head.cmd.lvl, head.cmd.sat, head.cmd.hue};
						s_tuser <= head.cmd.opcode;
						nv_s = 1'b1;
					end
				end
			end
			s_tvalid <= nv_s;
			cfg_valid <= nv_c;
		end
	end

	// receiver backpressure, with one long hold-off
	int unsigned burst_left = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	bit          rx_idle = 1'b0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && n_recv >= LONG_HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (burst_left == 0) begin
					if (n_recv + QUIET_TAIL >= n_total) begin
						rx_idle = 1'b0;
						burst_left = 1;
					end else if ($urandom_range(0, 2) == 0) begin
						rx_idle = 1'b1;
						burst_left = $urandom_range(1, 11);
					end else begin
						rx_idle = 1'b0;
						burst_left = $urandom_range(1, 40);
					end
				end
				burst_left--;
				m_tready <= !rx_idle;
			end
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		lamp_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (n_recv >= n_issued) begin
				$display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
					$time, m_tdata, m_tuser);
				error_count++;
			end else begin
				want = expected_results[n_recv];
				check_field("red_duty", n_recv, want.red, m_tdata[7:0]);
				check_field("green_duty", n_recv, want.green, m_tdata[15:8]);
				check_field("blue_duty", n_recv, want.blue, m_tdata[23:16]);
				check_field("warm_duty", n_recv, want.warm, m_tdata[31:24]);
				check_field("cold_duty", n_recv, want.cold, m_tdata[39:32]);
				check_field("fade_ms", n_recv, want.fade, m_tdata[55:40]);
				check_field("status", n_recv, want.status, m_tuser);
			end
			n_recv <= n_recv + 1;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** five_channel_light_color_mapper: FAILED **");
		$finish;
	end

	initial begin
		// reset state, fade time still at its reset value
		queue_cmd(OPC_SWITCH, 0, 0, 0, 0, 0, 1'b1);
		queue_cmd(OPC_COLOUR, 0, 100, 100, 0, 0, 1'b0);
		queue_cmd(OPC_COLOUR, 360, 100, 100, 127, 127, 1'b1);
		queue_cmd(OPC_COLOUR, 60, 100, 100, 0, 0, 1'b0);
		queue_cmd(OPC_COLOUR, 120, 50, 100, 0, 0, 1'b0);
		queue_cmd(OPC_COLOUR, 180, 100, 50, 0, 0, 1'b0);
		queue_cmd(OPC_COLOUR, 240, 100, 100, 0, 0, 1'b0);
		queue_cmd(OPC_COLOUR, 300, 75, 100, 0, 0, 1'b0);
		queue_cmd(OPC_COLOUR, 359, 100, 100, 0, 0, 1'b0);
		queue_cmd(OPC_COLOUR, 200, 0, 0, 0, 0, 1'b0);
		queue_cmd(OPC_SWITCH, 511, 127, 127, 127, 127, 1'b0);
		// zero level comes back at full
		queue_cmd(OPC_SWITCH, 0, 0, 0, 0, 0, 1'b1);
		queue_cmd(OPC_COLOUR, 361, 50, 50, 0, 0, 1'b0);
		queue_cmd(OPC_COLOUR, 511, 127, 127, 0, 0, 1'b0);
		queue_cmd(OPC_COLOUR, 10, 101, 50, 0, 0, 1'b0);
		queue_cmd(OPC_COLOUR, 10, 50, 101, 0, 0, 1'b0);
		queue_cmd(OPC_WHITE, 0, 0, 0, 0, 100, 1'b0);
		queue_cmd(OPC_WHITE, 511, 127, 127, 100, 100, 1'b1);
		queue_cmd(OPC_WHITE, 0, 0, 0, 50, 20, 1'b0);
		queue_cmd(OPC_WHITE, 0, 0, 0, 101, 50, 1'b0);
		queue_cmd(OPC_WHITE, 0, 0, 0, 50, 127, 1'b0);
		queue_cmd(OPC_WHITE, 0, 0, 0, 30, 0, 1'b0);
		queue_cmd(OPC_SWITCH, 0, 0, 0, 0, 0, 1'b0);
		// zero brightness comes back at full
		queue_cmd(OPC_SWITCH, 0, 0, 0, 0, 0, 1'b1);
		queue_cmd(OPC_UNUSED, 511, 127, 127, 127, 127, 1'b1);
		queue_cmd(OPC_SWITCH, 0, 0, 0, 0, 0, 1'b0);
		// set while off turns the lamp on
		queue_cmd(OPC_COLOUR, 90, 40, 60, 0, 0, 1'b0);
		queue_fade(16'hFFFF);
		queue_random(250);
		queue_fade(16'h0000);
		queue_random(250);
		queue_fade(16'($urandom));
		queue_random(250);
		queue_fade(16'h0001);
		queue_random(200);
		queue_fade(16'($urandom));
		queue_random(200);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (!(pending.size() == 0 && !s_tvalid && !cfg_valid && n_recv == n_issued))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("** five_channel_light_color_mapper: PASSED **");
		else
			$display("** five_channel_light_color_mapper: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
sv/fclcm_pkg.sv
sv/fclcm_ctrl.sv
sv/fclcm_datapath.sv
sv/five_channel_light_color_mapper.sv
sv/fclcm_checker.sv
test/tb_five_channel_light_color_mapper.sv
